// ===== src/knc_pkg.sv =====
// Shared types and constants for the k-means nearest-centroid block.
`default_nettype none

package knc_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned CLUSTER_W  = 4;
  localparam int unsigned DIM_W      = 4;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned PREV_W     = 5;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned DIST_W     = 40;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // Best-cluster index as carried down the chain: the active count is at
  // most 31, so five bits hold any cluster that can take part.
  localparam int unsigned BEST_IDX_W = COUNT_W;

  // Input item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CLUSTERS   = 1'b0,
    REG_ACTIVE_DIMENSIONS = 1'b1
  } knc_reg_e;

  // One input beat.
  typedef struct packed {
    logic                      mode;
    logic [CLUSTER_W-1:0]      cluster_index;
    logic [DIM_W-1:0]          dim_index;
    logic signed [COORD_W-1:0] coord_value;
    logic [PREV_W-1:0]         previous_cluster;
  } knc_in_t;

  // One result beat.
  typedef struct packed {
    logic [CLUSTER_W-1:0] nearest_cluster;
    logic [DIST_W-1:0]    nearest_distance;
    logic                 changed;
  } knc_out_t;

  // Token that travels from cell to cell.
  typedef struct packed {
    logic                      valid;
    logic                      load;
    logic                      load_ok;
    logic                      last;
    logic [CLUSTER_W-1:0]      cluster_index;
    logic [DIM_W-1:0]          dim_index;
    logic signed [COORD_W-1:0] coord_value;
    logic [PREV_W-1:0]         previous_cluster;
    logic                      best_valid;
    logic [BEST_IDX_W-1:0]     best_idx;
    logic [DIST_W-1:0]         best_dist;
  } knc_tok_t;

endpackage

`default_nettype wire

// ===== src/knc_cell.sv =====
// One cluster cell: centroid memory, squared-distance accumulator, running minimum.
`default_nettype none

module knc_cell #(
  parameter int CELL_INDEX     = 0,
  parameter int MAX_DIMENSIONS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  logic [knc_pkg::COUNT_W-1:0]       nclus_i,
  input  knc_pkg::knc_tok_t                 tok_i,
  output knc_pkg::knc_tok_t                 tok_o
);
  import knc_pkg::*;

  localparam int DAW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

  logic [COORD_W-1:0]      mem_q [MAX_DIMENSIONS];
  logic [COORD_W-1:0]      rd_q;
  logic [DAW+DIM_W-1:0]    dim_ext;
  logic [DAW-1:0]          addr;
  logic                    load_hit;

  knc_tok_t                s1_q;
  knc_tok_t                s2_q;
  knc_tok_t                tok_d;
  knc_tok_t                tok_q;

  logic signed [COORD_W:0]     diff;
  logic signed [2*COORD_W+1:0] prod;
  logic [SQ_W-1:0]             sq_q;

  logic [DIST_W-1:0]       acc_q;
  logic [DIST_W-1:0]       acc_d;
  logic [DIST_W:0]         sum;
  logic [DIST_W-1:0]       sat;
  logic                    active;
  logic                    point;

  // Address and write select for the centroid memory.
  assign dim_ext  = {{DAW{1'b0}}, tok_i.dim_index};
  assign addr     = dim_ext[DAW-1:0];
  assign load_hit = tok_i.valid && tok_i.load && tok_i.load_ok &&
                    (32'(tok_i.cluster_index) == 32'(CELL_INDEX));

  // Centroid coordinates of this cluster, one entry per dimension.
  always_ff @(posedge clk_i) begin
    if (advance_i && load_hit) begin
      mem_q[addr] <= tok_i.coord_value;
    end
    if (advance_i) begin
      rd_q <= mem_q[addr];
    end
  end

  // Difference and square of the coordinate against the centroid.
  assign diff = $signed({s1_q.coord_value[COORD_W-1], s1_q.coord_value}) -
                $signed({rd_q[COORD_W-1], rd_q});
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sq_q <= prod[SQ_W-1:0];
    end
  end

  // Accumulate with saturation, and fold this cell into the running minimum
  // on the last dimension of a point.
  assign active = (CELL_INDEX < int'(nclus_i));
  assign point  = s2_q.valid && !s2_q.load;
  assign sum    = {1'b0, acc_q} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_q};
  assign sat    = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_comb begin
    acc_d = acc_q;
    tok_d = s2_q;
    if (point && active) begin
      acc_d = s2_q.last ? '0 : sat;
      if (s2_q.last && (!s2_q.best_valid || (sat < s2_q.best_dist))) begin
        tok_d.best_valid = 1'b1;
        tok_d.best_idx   = BEST_IDX_W'(CELL_INDEX);
        tok_d.best_dist  = sat;
      end
    end else if (point && s2_q.last) begin
      acc_d = '0;
    end
  end

  // Pipeline registers of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      tok_q <= '0;
      acc_q <= '0;
    end else if (advance_i) begin
      s1_q  <= tok_i;
      s2_q  <= s1_q;
      tok_q <= tok_d;
      acc_q <= acc_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== src/kmeans_nearest_centroid.sv =====
// Top level of the k-means nearest-centroid assignment block.
//
// Usage: input beats on in_valid_i/in_stall_o/in_item_i either load one
// centroid coordinate (mode 0) or carry one coordinate of a point (mode 1).
// Each cluster has its own cell in a chain; a beat enters cell 0 and moves
// one cell stage per cycle, so one beat is taken every cycle unless the
// chain stalls. A point beat whose dimension is the last active one produces
// one result beat on out_valid_o/out_stall_i/out_item_o with the nearest
// cluster, its squared distance and a changed flag, after the three stages of
// each cell (memory read, square, accumulate) and the output register. A point
// beat for an inactive dimension is taken and dropped. Configuration is written
// through cfg_we_i/cfg_index_i/cfg_wdata_i; the user must write it only while
// the block is idle, which the block does not enforce. Reset clears the
// accumulators, pipeline tokens and output valid flag and sets both active
// counts to 16; centroid memories hold nothing defined until written. When the
// receiver stalls, the chain moves on until a result reaches its end, then holds.
`default_nettype none

module kmeans_nearest_centroid #(
  parameter int MAX_CLUSTERS   = 16,
  parameter int MAX_DIMENSIONS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  knc_pkg::knc_in_t                   in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output knc_pkg::knc_out_t                  out_item_o,
  input  logic                               cfg_we_i,
  input  logic [knc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [knc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import knc_pkg::*;

  logic [COUNT_W-1:0] act_clus_q;
  logic [COUNT_W-1:0] act_dims_q;
  logic [COUNT_W-1:0] nclus;
  logic [COUNT_W-1:0] ndim;
  int                 ncl_int;
  int                 ndm_int;

  knc_tok_t           chain [MAX_CLUSTERS+1];
  knc_tok_t           tail;
  logic               accept;
  logic               in_range;
  logic               tail_result;
  logic               advance;

  logic               out_valid_q;
  knc_out_t           out_item_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_clus_q <= COUNT_W'(16);
      act_dims_q <= COUNT_W'(16);
    end else if (cfg_we_i) begin
      unique case (knc_reg_e'(cfg_index_i))
        REG_ACTIVE_CLUSTERS:   act_clus_q <= cfg_wdata_i;
        REG_ACTIVE_DIMENSIONS: act_dims_q <= cfg_wdata_i;
        default:               act_clus_q <= act_clus_q;
      endcase
    end
  end

  // Effective counts: zero acts as one, and the memory sizes cap them.
  always_comb begin
    ncl_int = int'(act_clus_q);
    ndm_int = int'(act_dims_q);
    if (ncl_int == 0) begin
      ncl_int = 1;
    end else if (ncl_int > MAX_CLUSTERS) begin
      ncl_int = MAX_CLUSTERS;
    end
    if (ndm_int == 0) begin
      ndm_int = 1;
    end else if (ndm_int > MAX_DIMENSIONS) begin
      ndm_int = MAX_DIMENSIONS;
    end
  end

  assign nclus = COUNT_W'(ncl_int);
  assign ndim  = COUNT_W'(ndm_int);

  // Stall control: the chain only holds when a result sits at its end and
  // the output register cannot take it.
  assign tail        = chain[MAX_CLUSTERS];
  assign tail_result = tail.valid && !tail.load && tail.last;
  assign advance     = !(out_valid_q && out_stall_i && tail_result);
  assign in_stall_o  = !advance;
  assign accept      = in_valid_i && advance;

  // Build the token for the head of the chain.
  assign in_range = ({1'b0, in_item_i.dim_index} < ndim);

  always_comb begin
    chain[0]                  = '0;
    chain[0].load             = (in_item_i.mode == MODE_LOAD);
    chain[0].valid            = accept && ((in_item_i.mode == MODE_LOAD) || in_range);
    chain[0].load_ok          = (32'(in_item_i.dim_index) < 32'(MAX_DIMENSIONS));
    chain[0].last             = ({1'b0, in_item_i.dim_index} == (ndim - COUNT_W'(1)));
    chain[0].cluster_index    = in_item_i.cluster_index;
    chain[0].dim_index        = in_item_i.dim_index;
    chain[0].coord_value      = in_item_i.coord_value;
    chain[0].previous_cluster = in_item_i.previous_cluster;
  end

  // One cell per cluster.
  for (genvar c = 0; c < MAX_CLUSTERS; c++) begin : g_cell
    knc_cell #(
      .CELL_INDEX     (c),
      .MAX_DIMENSIONS (MAX_DIMENSIONS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .nclus_i   (nclus),
      .tok_i     (chain[c]),
      .tok_o     (chain[c+1])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && tail_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tail_result) begin
      out_item_q.nearest_cluster  <= tail.best_idx[CLUSTER_W-1:0];
      out_item_q.nearest_distance <= tail.best_dist;
      out_item_q.changed          <= (tail.previous_cluster != tail.best_idx);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
